// ===== hw/rtl/snapshot_rle_block_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Snapshot RLE block decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_RLE_BLOCK_DECODER_ASSERT_SVH
`define SNAPSHOT_RLE_BLOCK_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SRLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define SRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srle_pkg.sv =====
// ----------------------------------------------------------------------------
// Snapshot RLE block decoder package
// Shared types and constants for the decoder stage and the result queue.
// ----------------------------------------------------------------------------
package srle_pkg;

  // Escape marker of the compressed stream
  localparam logic [7:0] ESCAPE_BYTE = 8'd237;

  // Default depth of the result queue (power of two, at least 2)
  localparam int unsigned RESULT_DEPTH = 4;

  // Escape sequence position
  typedef enum logic [1:0] {
    PH_LITERAL = 2'd0,
    PH_ESC     = 2'd1,
    PH_COUNT   = 2'd2,
    PH_VALUE   = 2'd3
  } phase_e;

  // One memory write command
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic [7:0]  count;
    logic        block_end;
  } cmd_t;

  // Commands produced by one input byte (num is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] num;
    cmd_t       cmd0;
    cmd_t       cmd1;
  } res_push_t;

endpackage

// ===== hw/rtl/snapshot_rle_block_decoder.sv =====
// ----------------------------------------------------------------------------
// Snapshot RLE block decoder
// Turns a compressed snapshot byte stream into memory write commands.
// ----------------------------------------------------------------------------
// Takes one compressed byte per cycle while the result queue has room, and
// returns memory write commands (address, value, repeat count, block end).
// A byte enters an input register and is decoded, once the queue has room
// for two commands, into zero, one or two commands that go into a small
// result queue. Input is taken every cycle as long as the queue keeps room
// for two commands; an escape pair yields two results, so the sustained
// rate is then set by the output side at one result per cycle.
// The start address comes from the configuration register when a block's
// first byte is decoded; a new value takes effect from the next block.
// ----------------------------------------------------------------------------
module snapshot_rle_block_decoder #(
  parameter int unsigned ResultDepth = srle_pkg::RESULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Compressed byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        last_byte_i,
  // Write command output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_value_o,
  output logic [7:0]  repeat_count_o,
  output logic        block_end_o
);

  logic [15:0]         dest_base_q;
  logic                space_ok;
  srle_pkg::res_push_t push;
  srle_pkg::cmd_t      out_cmd;

  // Take a configuration transaction in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q <= 16'd0;
    end else if (cfg_valid_i) begin
      dest_base_q <= cfg_data_i;
    end
  end

  // Decode stage
  srle_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .last_byte_i (last_byte_i),
    .dest_base_i (dest_base_q),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  // Result queue
  srle_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_cmd_o   (out_cmd)
  );

  assign write_address_o = out_cmd.addr;
  assign write_value_o   = out_cmd.value;
  assign repeat_count_o  = out_cmd.count;
  assign block_end_o     = out_cmd.block_end;

endmodule

// ===== hw/rtl/srle_decode.sv =====
// ----------------------------------------------------------------------------
// Snapshot RLE decode stage
// Input register, escape sequence state and the per-byte command decode.
// ----------------------------------------------------------------------------
`include "snapshot_rle_block_decoder_assert.svh"

module srle_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_in_i,
  input  logic                last_byte_i,
  input  logic [15:0]         dest_base_i,
  input  logic                space_ok_i,
  output srle_pkg::res_push_t push_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  logic                fire;

  srle_pkg::phase_e    phase_q, phase_d, phase_cur;
  logic [7:0]          run_len_q, run_len_d, run_len_cur;
  logic [15:0]         ptr_q, ptr_d, ptr_cur;
  logic                in_block_q, in_block_d;
  srle_pkg::res_push_t res;

  // Decode the held byte once the result queue has room for two commands
  assign fire       = in_valid_q && space_ok_i;
  assign in_ready_o = !in_valid_q || space_ok_i;

  // Hold the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= byte_in_i;
      in_last_q <= last_byte_i;
    end
  end

  // Start a block from the base address when no block is under way
  assign ptr_cur     = in_block_q ? ptr_q : dest_base_i;
  assign phase_cur   = in_block_q ? phase_q : srle_pkg::PH_LITERAL;
  assign run_len_cur = in_block_q ? run_len_q : 8'd0;

  // Decode one byte into up to two commands
  always_comb begin
    res        = '0;
    phase_d    = phase_cur;
    run_len_d  = run_len_cur;
    ptr_d      = ptr_cur;
    in_block_d = 1'b1;

    case (phase_cur)
      srle_pkg::PH_LITERAL: begin
        if (in_byte_q != srle_pkg::ESCAPE_BYTE) begin
          res.num   = 2'd1;
          res.cmd0  = '{addr: ptr_cur, value: in_byte_q, count: 8'd1, block_end: 1'b0};
          ptr_d     = ptr_cur + 16'd1;
        end else begin
          phase_d = srle_pkg::PH_ESC;
        end
      end
      srle_pkg::PH_ESC: begin
        if (in_byte_q != srle_pkg::ESCAPE_BYTE) begin
          res.num  = 2'd2;
          res.cmd0 = '{addr: ptr_cur, value: srle_pkg::ESCAPE_BYTE, count: 8'd1,
                       block_end: 1'b0};
          res.cmd1 = '{addr: ptr_cur + 16'd1, value: in_byte_q, count: 8'd1,
                       block_end: 1'b0};
          ptr_d    = ptr_cur + 16'd2;
          phase_d  = srle_pkg::PH_LITERAL;
        end else begin
          phase_d = srle_pkg::PH_COUNT;
        end
      end
      srle_pkg::PH_COUNT: begin
        run_len_d = in_byte_q;
        phase_d   = srle_pkg::PH_VALUE;
      end
      srle_pkg::PH_VALUE: begin
        res.num   = 2'd1;
        res.cmd0  = '{addr: ptr_cur, value: in_byte_q, count: run_len_cur, block_end: 1'b0};
        ptr_d     = ptr_cur + {8'd0, run_len_cur};
        run_len_d = 8'd0;
        phase_d   = srle_pkg::PH_LITERAL;
      end
      default: begin
        phase_d = srle_pkg::PH_LITERAL;
      end
    endcase

    // Close the block: drop a truncated escape, flag the final command
    if (in_last_q) begin
      if (res.num == 2'd0) begin
        res.num  = 2'd1;
        res.cmd0 = '{addr: ptr_cur, value: 8'd0, count: 8'd0, block_end: 1'b0};
      end
      if (res.num == 2'd2) begin
        res.cmd1.block_end = 1'b1;
      end else begin
        res.cmd0.block_end = 1'b1;
      end
      phase_d    = srle_pkg::PH_LITERAL;
      run_len_d  = 8'd0;
      in_block_d = 1'b0;
    end

    push_o = res;
    if (!fire) begin
      push_o.num = 2'd0;
    end
  end

  // Advance the sequence state on each decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= srle_pkg::PH_LITERAL;
      run_len_q  <= 8'd0;
      ptr_q      <= 16'd0;
      in_block_q <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      run_len_q  <= run_len_d;
      ptr_q      <= ptr_d;
      in_block_q <= in_block_d;
    end
  end

  // Outside a block the sequence state sits at its idle values
  `SRLE_ASSERT(a_idle_state, !in_block_q |-> (phase_q == srle_pkg::PH_LITERAL && run_len_q == 8'd0), "sequence state not idle outside a block")
  // A last byte closes the block
  `SRLE_ASSERT_NEXT(a_last_closes, fire && in_last_q, !in_block_q, "block still open after last byte")
  // An escape pair writes two neighboring addresses
  `SRLE_ASSERT(a_pair_addr, push_o.num == 2'd2 |-> push_o.cmd1.addr == push_o.cmd0.addr + 16'd1, "escape pair addresses not adjacent")

endmodule

// ===== hw/rtl/srle_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Snapshot RLE result queue
// Small register queue taking up to two commands a cycle, giving one when the reader is ready.
// ----------------------------------------------------------------------------
`include "snapshot_rle_block_decoder_assert.svh"

module srle_result_fifo #(
  parameter int unsigned Depth = srle_pkg::RESULT_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srle_pkg::res_push_t push_i,
  output logic                space_ok_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srle_pkg::cmd_t      out_cmd_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  srle_pkg::cmd_t    mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, free;
  logic              pop;

  assign free        = CntW'(Depth) - count_q;
  assign space_ok_o  = free >= CntW'(2);
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = mem_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.cmd0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + IdxW'(1)] <= push_i.cmd1;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + IdxW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + IdxW'(1);
      end
      count_q <= count_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

  // Fill count stays within the queue
  `SRLE_ASSERT(a_count_range, count_q <= CntW'(Depth), "result queue count out of range")
  // Never push more than there is room for
  `SRLE_ASSERT(a_no_overflow, push_i.num != 2'd0 |-> free >= CntW'(push_i.num), "result queue overflow")
  // A pop without push shrinks the queue by one
  `SRLE_ASSERT_NEXT(a_pop_only, pop && push_i.num == 2'd0, count_q == $past(count_q) - CntW'(1), "result queue count not decremented")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot RLE block decoder testbench
// Streams compressed blocks into the decoder and scores every write command
// against a cycle-free prediction of the escape/run decoding, with random
// stalls on both sides and several start addresses, including both extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned PhaseItems   = 175;

  // DUT signals
  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in_i    = '0;
  logic        last_byte_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [15:0] write_address_o;
  logic [7:0]  write_value_o;
  logic [7:0]  repeat_count_o;
  logic        block_end_o;

  // Decoder prediction state
  logic [15:0]      base_addr  = '0;
  logic [15:0]      next_addr  = '0;
  logic [7:0]       held_count = '0;
  srle_pkg::phase_e esc_phase  = srle_pkg::PH_LITERAL;
  logic             block_open = 1'b0;

  // Write commands predicted but not yet seen
  srle_pkg::cmd_t pending_cmds[$];

  // Run bookkeeping
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned blocks_sent  = 0;
  int unsigned cmds_checked = 0;
  int unsigned base_writes  = 0;
  int unsigned stall_left   = 0;
  bit          quiet_mode   = 1'b0;

  snapshot_rle_block_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_in_i       (byte_in_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_value_o   (write_value_o),
    .repeat_count_o  (repeat_count_o),
    .block_end_o     (block_end_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("ERROR: %s", msg);
  endfunction

  function automatic srle_pkg::cmd_t make_cmd(input logic [15:0] addr,
                                              input logic [7:0] value,
                                              input logic [7:0] count);
    srle_pkg::cmd_t c;
    c.addr      = addr;
    c.value     = value;
    c.count     = count;
    c.block_end = 1'b0;
    return c;
  endfunction

  // Decode one accepted byte and queue the commands it produces
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    srle_pkg::cmd_t made[$];
    // Load the start address on the first byte of a block
    if (!block_open) begin
      next_addr  = base_addr;
      esc_phase  = srle_pkg::PH_LITERAL;
      held_count = '0;
      block_open = 1'b1;
    end
    case (esc_phase)
      srle_pkg::PH_LITERAL: begin
        if (b != srle_pkg::ESCAPE_BYTE) begin
          made.push_back(make_cmd(next_addr, b, 8'd1));
          next_addr = next_addr + 16'd1;
        end else begin
          esc_phase = srle_pkg::PH_ESC;
        end
      end
      srle_pkg::PH_ESC: begin
        // A lone escape stands for itself followed by the byte
        if (b != srle_pkg::ESCAPE_BYTE) begin
          made.push_back(make_cmd(next_addr, srle_pkg::ESCAPE_BYTE, 8'd1));
          next_addr = next_addr + 16'd1;
          made.push_back(make_cmd(next_addr, b, 8'd1));
          next_addr = next_addr + 16'd1;
          esc_phase = srle_pkg::PH_LITERAL;
        end else begin
          esc_phase = srle_pkg::PH_COUNT;
        end
      end
      srle_pkg::PH_COUNT: begin
        held_count = b;
        esc_phase  = srle_pkg::PH_VALUE;
      end
      default: begin
        made.push_back(make_cmd(next_addr, b, held_count));
        next_addr  = next_addr + {8'd0, held_count};
        held_count = '0;
        esc_phase  = srle_pkg::PH_LITERAL;
      end
    endcase
    // Close the block; a truncated escape still yields an empty end command
    if (last) begin
      if (made.size() == 0) made.push_back(make_cmd(next_addr, 8'd0, 8'd0));
      made[made.size() - 1].block_end = 1'b1;
      esc_phase  = srle_pkg::PH_LITERAL;
      held_count = '0;
      block_open = 1'b0;
      blocks_sent++;
    end
    foreach (made[i]) pending_cmds.push_back(made[i]);
  endfunction

  // Send one byte; hold valid until the transaction, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    byte_in_i   <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, last);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic close_block);
    foreach (seq[i]) send_byte(seq[i], close_block && (i == seq.size() - 1));
  endtask

  // Stop sending and wait until every predicted command has come out
  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    base_addr = value;
    base_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Check each command transaction against the oldest prediction
  always @(posedge clk_i) begin
    srle_pkg::cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        note_error($sformatf("unexpected command addr=%h val=%h cnt=%0d end=%b",
                             write_address_o, write_value_o, repeat_count_o, block_end_o));
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (write_address_o !== want.addr || write_value_o !== want.value ||
            repeat_count_o !== want.count || block_end_o !== want.block_end) begin
          note_error($sformatf({"command %0d: expected addr=%h val=%h cnt=%0d end=%b,",
                                " got addr=%h val=%h cnt=%0d end=%b"}, cmds_checked,
                               want.addr, want.value, want.count, want.block_end,
                               write_address_o, write_value_o, repeat_count_o,
                               block_end_o));
        end
      end
    end
  end

  // Stall the command output at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  function automatic logic [7:0] pick_literal();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == srle_pkg::ESCAPE_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 30) return 8'd1;
    if (r < 35) return srle_pkg::ESCAPE_BYTE;
    return 8'($urandom_range(2, 40));
  endfunction

  // Literals across the top, escape pair, long run, zero run ending a block
  task automatic test_literal_and_runs();
    write_base(16'hFFFE);
    send_seq('{8'h00, 8'hFF, 8'hEE}, 1'b0);
    send_seq('{srle_pkg::ESCAPE_BYTE, 8'h00}, 1'b0);
    send_seq('{srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE, 8'd255, 8'hAA}, 1'b0);
    send_seq('{srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE, 8'd0, 8'h55}, 1'b1);
    // Block of one opening escape only
    send_seq('{srle_pkg::ESCAPE_BYTE}, 1'b1);
  endtask

  // Escape bytes as count and value, and blocks cut inside an escape
  task automatic test_truncated_endings();
    wait_idle();
    write_base(16'h0000);
    send_seq('{srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE,
               srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE}, 1'b0);
    send_seq('{srle_pkg::ESCAPE_BYTE, 8'hFF}, 1'b1);
    send_seq('{srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE, 8'd9}, 1'b1);
    send_seq('{srle_pkg::ESCAPE_BYTE, srle_pkg::ESCAPE_BYTE}, 1'b1);
  endtask

  // New base written inside an open block must wait for the next block
  task automatic test_base_change_mid_block();
    wait_idle();
    send_seq('{8'h12, srle_pkg::ESCAPE_BYTE}, 1'b0);
    wait_idle();
    write_base(16'h1234);
    send_seq('{8'h01}, 1'b1);
    send_seq('{8'h7E}, 1'b1);
  endtask

  // Mostly well-formed tokens with random content, plus noise and cut blocks
  task automatic send_random_block(input int unsigned max_tokens);
    logic [7:0] body_q[$];
    int unsigned tokens;
    int unsigned kind;
    tokens = $urandom_range(1, max_tokens);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        body_q.push_back(pick_literal());
      end else if (kind < 60) begin
        body_q.push_back(srle_pkg::ESCAPE_BYTE);
        body_q.push_back(pick_literal());
      end else if (kind < 85) begin
        body_q.push_back(srle_pkg::ESCAPE_BYTE);
        body_q.push_back(srle_pkg::ESCAPE_BYTE);
        body_q.push_back(pick_count());
        body_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Sometimes end the block in the middle of an escape
    kind = $urandom_range(0, 99);
    if (kind < 14) body_q.push_back(srle_pkg::ESCAPE_BYTE);
    if (kind >= 6 && kind < 14) body_q.push_back(srle_pkg::ESCAPE_BYTE);
    if (kind >= 10 && kind < 14) body_q.push_back(pick_count());
    send_seq(body_q, 1'b1);
  endtask

  task automatic test_random_blocks();
    logic [15:0] phase_base;
    int unsigned start;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0:       phase_base = 16'hFFFF;
        1:       phase_base = 16'h0000;
        2:       phase_base = 16'($urandom_range(0, 65535));
        default: phase_base = 16'hFF00 | 16'($urandom_range(0, 255));
      endcase
      write_base(phase_base);
      // One phase runs without any idling on either side
      quiet_mode = (p == 1);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        send_random_block(12);
        // Occasionally let the output drain completely
        if ($urandom_range(0, 99) < 3) wait_idle();
      end
      quiet_mode = 1'b0;
    end
  endtask

  // Main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_literal_and_runs();
    test_truncated_endings();
    test_base_change_mid_block();
    test_random_blocks();
    wait_idle();
    while (pending_cmds.size() != 0) begin
      srle_pkg::cmd_t left;
      left = pending_cmds.pop_front();
      note_error($sformatf("missing command addr=%h val=%h cnt=%0d end=%b",
                           left.addr, left.value, left.count, left.block_end));
    end
    $display("Summary: %0d bytes in %0d blocks, %0d commands checked, %0d base writes",
             items_sent, blocks_sent, cmds_checked, base_writes);
    $display("Summary: %0d failures", error_count);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/srle_pkg.sv
hw/rtl/srle_decode.sv
hw/rtl/srle_result_fifo.sv
hw/rtl/snapshot_rle_block_decoder.sv
dv/tb_top.sv
